[hw/rtl/b64e_pkg.sv]
// Shared types and constants for the base64 byte stream encoder.
// No dependencies; imported by every module of the block.
package b64e_pkg;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [7:0] UPPER_A  = 8'h41;
  localparam logic [7:0] LOWER_A  = 8'h61;
  localparam logic [7:0] DIGIT_0  = 8'h30;
  localparam logic [7:0] PLUS_CH  = 8'h2B;
  localparam logic [7:0] SLASH_CH = 8'h2F;

  // One encoded byte: up to four characters, emitted in order
  typedef struct packed {
    logic [1:0]      cnt_m1;  // number of characters minus one
    logic [3:0][7:0] chars;   // chars[0] goes out first
    logic            fin;     // final character closes the message
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = UPPER_A + w;
    end else if (v < 6'd52) begin
      c = LOWER_A + w - 8'd26;
    end else if (v < 6'd62) begin
      c = DIGIT_0 + w - 8'd52;
    end else if (v == 6'd62) begin
      c = PLUS_CH;
    end else begin
      c = SLASH_CH;
    end
    return c;
  endfunction

endpackage

[hw/rtl/b64e_front.sv]
// Front end: tracks the position in the 3-byte group and turns each byte into a job.
// Depends on b64e_pkg.
module b64e_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    data_byte,
  input  logic          end_of_message,
  output b64e_pkg::job_t job
);
  import b64e_pkg::*;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [3:0] leftover;
  logic [3:0] leftover_next;

  always_comb begin
    job           = '0;
    job.fin       = end_of_message;
    phase_next    = PH_FIRST;
    leftover_next = 4'd0;
    case (phase)
      PH_SECOND: begin
        job.chars[0] = sextet_char({leftover[1:0], data_byte[7:4]});
        if (end_of_message) begin
          job.cnt_m1   = 2'd2;
          job.chars[1] = sextet_char({data_byte[3:0], 2'b00});
          job.chars[2] = PAD_CHAR;
        end else begin
          job.cnt_m1    = 2'd0;
          phase_next    = PH_THIRD;
          leftover_next = data_byte[3:0];
        end
      end
      PH_THIRD: begin
        job.cnt_m1   = 2'd1;
        job.chars[0] = sextet_char({leftover, data_byte[7:6]});
        job.chars[1] = sextet_char(data_byte[5:0]);
      end
      default: begin
        // unused phase code counts as a group start
        job.chars[0] = sextet_char(data_byte[7:2]);
        if (end_of_message) begin
          job.cnt_m1   = 2'd3;
          job.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
          job.chars[2] = PAD_CHAR;
          job.chars[3] = PAD_CHAR;
        end else begin
          job.cnt_m1    = 2'd0;
          phase_next    = PH_SECOND;
          leftover_next = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FIRST;
      leftover <= 4'd0;
    end else if (take) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

[hw/rtl/b64e_queue.sv]
// Short job queue between front and back end.
// Depends on b64e_pkg.
module b64e_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  b64e_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output b64e_pkg::job_t rd_data,
  output logic           empty
);
  import b64e_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == DEPTH_CNT);
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en && !empty) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en && !full, rd_en && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/b64e_back.sv]
// Back end: walks the characters of each job and feeds the output register.
// Depends on b64e_pkg.
module b64e_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  b64e_pkg::job_t q_job,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_char,
  output logic           last_char
);
  import b64e_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic       cur_valid_next;
  logic [1:0] idx;
  logic [1:0] idx_next;
  logic       out_valid;
  logic       out_valid_next;
  logic       load_out;
  logic       cur_done;
  logic       pop_ok;

  assign empty = !out_valid;

  always_comb begin
    pop_ok         = pop && out_valid;
    load_out       = cur_valid && (!out_valid || pop_ok);
    cur_done       = load_out && (idx == cur.cnt_m1);
    q_pop          = !q_empty && (!cur_valid || cur_done);
    out_valid_next = load_out || (out_valid && !pop_ok);
    cur_valid_next = q_pop || (cur_valid && !cur_done);
    idx_next       = idx;
    if (q_pop) begin
      idx_next = 2'd0;
    end else if (load_out) begin
      idx_next = idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      cur_valid <= cur_valid_next;
      out_valid <= out_valid_next;
      idx       <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
    if (load_out) begin
      out_char  <= cur.chars[idx];
      last_char <= cur.fin && (idx == cur.cnt_m1);
    end
  end

endmodule

[hw/rtl/base64_byte_stream_encoder.sv]
// Top level of the base64 byte stream encoder: front end, job queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
//   channel   handshake           payload
//   input     push / full         data_byte[7:0], end_of_message
//   result    empty / pop         out_char[7:0], last_char
//
// One byte is taken per cycle while the queue has room; the back end sends one
// character per cycle from its single output register while the result side pops.
// A byte's job passes a queue slot and the current-job register before its first
// character is loaded. Reset (rst, synchronous) empties the queue and returns to
// a group start. A stalled result side fills the queue and then raises full.
module base64_byte_stream_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       last_char
);
  import b64e_pkg::*;

  job_t front_job;
  job_t head_job;
  logic take;
  logic q_empty;
  logic q_pop;

  assign take = push && !full;

  b64e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .job            (front_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take),
    .wr_data (front_job),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (head_job),
    .empty   (q_empty)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_char  (out_char),
    .last_char (last_char)
  );

endmodule

[hw/rtl/b64e_checker.sv]
// Port-level checks for the base64 byte stream encoder, bound to the top level.
// Depends on b64e_pkg and base64_byte_stream_encoder.
module b64e_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char,
  input logic       last_char
);
  import b64e_pkg::*;

  // reset leaves nothing to deliver and room to take
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queue not cleared by reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(last_char)))
    else $error("result changed while stalled");

  // only alphabet characters or padding leave the block
  a_alphabet: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((out_char >= 8'h41 && out_char <= 8'h5A) ||
                (out_char >= 8'h61 && out_char <= 8'h7A) ||
                (out_char >= 8'h30 && out_char <= 8'h39) ||
                out_char == PLUS_CH || out_char == SLASH_CH || out_char == PAD_CHAR))
    else $error("character outside the base64 alphabet");

  // a first pad is followed at once by the closing pad
  a_pad_pair: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && out_char == PAD_CHAR && !last_char) |=>
      (!empty && out_char == PAD_CHAR && last_char))
    else $error("padding not closed by a final pad");

  // a final pad is not followed at once by another pad
  a_pad_tail: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && out_char == PAD_CHAR && last_char) |=>
      (empty || out_char != PAD_CHAR))
    else $error("padding after the end of a message");

endmodule

bind base64_byte_stream_encoder b64e_checker u_b64e_checker (.*);

[tb/sv/base64_byte_stream_encoder_test.sv]
// Self-checking testbench for base64_byte_stream_encoder: random and directed messages,
// a clocked driver and monitor, and an in-bench base64 encoder that predicts each character.
// Depends on b64e_pkg and the base64_byte_stream_encoder RTL.
module base64_byte_stream_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import b64e_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 5;
  localparam int HOLD_CYCLES  = 250;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE       = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } msg_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_message = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_char;
  logic       last_char;

  msg_byte_t bytes_to_send[$];
  enc_char_t expected_chars[$];

  // encoder state tracked by the bench
  logic [1:0] enc_phase = PH_FIRST;
  logic [3:0] enc_carry = 4'h0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_trig = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  int errors = 0;
  int bytes_sent = 0;
  int messages_sent = 0;
  int chars_checked = 0;
  int quiet_cycles = 0;

  base64_byte_stream_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .end_of_message(end_of_message),
    .empty         (empty),
    .pop           (pop),
    .out_char      (out_char),
    .last_char     (last_char)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    case (v) inside
      [6'd0:6'd25]:  c = UPPER_A + {2'b00, v};
      [6'd26:6'd51]: c = LOWER_A + ({2'b00, v} - 8'd26);
      [6'd52:6'd61]: c = DIGIT_0 + ({2'b00, v} - 8'd52);
      6'd62:         c = PLUS_CH;
      default:       c = SLASH_CH;
    endcase
    return c;
  endfunction

  function automatic void add_expected(input logic [7:0] ch, input logic last);
    enc_char_t e;
    e.ch = ch;
    e.last = last;
    expected_chars.push_back(e);
  endfunction

  // Advance the bench's encoder by one byte and queue the characters it completes.
  function automatic void predict_chars(input logic [7:0] b, input logic fin);
    case (enc_phase)
      PH_SECOND: begin
        add_expected(b64_char({enc_carry[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          add_expected(b64_char({b[3:0], 2'b00}), 1'b0);
          add_expected(PAD_CHAR, 1'b1);
          enc_phase = PH_FIRST;
          enc_carry = 4'h0;
        end else begin
          enc_phase = PH_THIRD;
          enc_carry = b[3:0];
        end
      end
      PH_THIRD: begin
        add_expected(b64_char({enc_carry, b[7:6]}), 1'b0);
        add_expected(b64_char(b[5:0]), fin);
        enc_phase = PH_FIRST;
        enc_carry = 4'h0;
      end
      default: begin
        add_expected(b64_char(b[7:2]), 1'b0);
        if (fin) begin
          add_expected(b64_char({b[1:0], 4'h0}), 1'b0);
          add_expected(PAD_CHAR, 1'b0);
          add_expected(PAD_CHAR, 1'b1);
          enc_phase = PH_FIRST;
          enc_carry = 4'h0;
        end else begin
          enc_phase = PH_SECOND;
          enc_carry = {2'b00, b[1:0]};
        end
      end
    endcase
  endfunction

  // Driver: hold the beat while full, otherwise offer the next pending byte or idle.
  always @(posedge clk) begin
    msg_byte_t nxt;
    if (rst) begin
      push <= 1'b0;
      data_byte <= 8'h00;
      end_of_message <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_chars(data_byte, end_of_message);
        bytes_sent++;
        if (end_of_message) messages_sent++;
      end
      if (!(push && full)) begin
        if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = bytes_to_send.pop_front();
          push <= 1'b1;
          data_byte <= nxt.data;
          end_of_message <= nxt.fin;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each popped character with the oldest prediction.
  always @(posedge clk) begin
    enc_char_t e;
    if (rst) begin
      pop <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_trig;
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character %h (last_char %b)", out_char, last_char);
          errors++;
        end else begin
          e = expected_chars.pop_front();
          chars_checked++;
          if (out_char !== e.ch) begin
            $error("out_char: expected %h, got %h", e.ch, out_char);
            errors++;
          end
          if (last_char !== e.last) begin
            $error("last_char: expected %b, got %b", e.last, last_char);
            errors++;
          end
        end
      end
      if (hold_trig != hold_seen) begin
        hold_seen <= hold_trig;
        hold_left <= HOLD_CYCLES;
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic fin);
    msg_byte_t m;
    m.data = b;
    m.fin = fin;
    bytes_to_send.push_back(m);
  endtask

  task automatic queue_random_message(input int len);
    for (int i = 0; i < len; i++) begin
      queue_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // Fill with random messages, mostly short, now and then a long one.
  task automatic queue_random_bytes(input int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      queue_random_message(len);
      n += len;
    end
  endtask

  // Wait until every byte is accepted and every character has been checked.
  task automatic wait_drained();
    @(posedge clk);
    while (bytes_to_send.size() != 0 || push || expected_chars.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random_bytes(count);
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // one-byte messages: flush with two pads
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    // two-byte messages: flush with one pad
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // full groups ending the message on the third byte
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'hBE, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    // five-byte message: a full group then a partial one
    queue_byte(8'h4D, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h6E, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b1);
    // four-byte message: flush after a single byte of the second group
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hFE, 1'b1);
    wait_drained();

    run_phase(0, 0, 100);
    run_phase(68, 0, 100);
    run_phase(0, 68, 100);
    run_phase(11, 11, 100);

    // long receiver hold-off while the sender keeps offering bytes
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random_bytes(40);
    hold_trig <= ~hold_trig;
    wait_drained();

    repeat (SETTLE) @(posedge clk);
    $display("Encoded %0d bytes in %0d messages and checked %0d characters,",
             bytes_sent, messages_sent, chars_checked);
    $display("across idle, stalled and back-pressured phases; %0d mismatches", errors);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
